>>> hdl/cswr_pkg.sv
// Shared types, constants and fixed-point helpers for the curved scalar wave RHS unit.
// No dependencies; every other file in hdl/ depends on this package.

package cswr_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int PIPE_DEPTH = 5;

    typedef logic signed [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAMMA1 = CFG_IDX_W'(0),
        CFG_GAMMA2 = CFG_IDX_W'(1)
    } cfg_reg_t;

    // One grid point
    typedef struct packed {
        word_t grad_psi;
        word_t grad_pi;
        word_t grad_phi;
        word_t pi_value;
        word_t phi_value;
        word_t lapse_value;
        word_t shift_value;
        word_t grad_lapse;
        word_t grad_shift;
        word_t inv_metric;
        word_t christoffel_trace;
        word_t extrinsic_trace;
    } point_t;

    // One result
    typedef struct packed {
        word_t psi_rate;
        word_t pi_rate;
        word_t phi_rate;
    } rates_t;

    // Damping settings seen by the datapath
    typedef struct packed {
        word_t gamma1;
        word_t gamma2;
        logic  gamma1_on;
    } cswr_cfg_t;

    // Per-stage load strobes from the pipeline control
    typedef struct packed {
        logic [PIPE_DEPTH-1:0] load;
    } cswr_pipe_ctl_t;

    // Saturating add
    function automatic word_t q_add(input word_t a, input word_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? WORD_MIN : WORD_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Saturating subtract
    function automatic word_t q_sub(input word_t a, input word_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1])
            return s[DATA_W] ? WORD_MIN : WORD_MAX;
        return s[DATA_W-1:0];
    endfunction

    // Saturating negate: most negative maps to most positive
    function automatic word_t q_neg(input word_t a);
        if (a == WORD_MIN)
            return WORD_MAX;
        return -a;
    endfunction

    // Fixed-point multiply: floor shift by FRAC_BITS, then saturate
    function automatic word_t q_mul(input word_t a, input word_t b);
        logic signed [2*DATA_W-1:0] p;
        logic signed [2*DATA_W-1:0] q;
        logic [DATA_W:0]            top;
        p   = (2*DATA_W)'(a) * (2*DATA_W)'(b);
        q   = p >>> FRAC_BITS;
        top = q[2*DATA_W-1:DATA_W-1];
        if ((&top) || !(|top))
            return q[DATA_W-1:0];
        return q[2*DATA_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

endpackage

>>> hdl/cswr_in_if.sv
// Input channel: one grid point per item, valid/ready handshake.
// Depends on cswr_pkg.

interface cswr_in_if;
    logic           valid;
    logic           ready;
    cswr_pkg::word_t grad_psi;
    cswr_pkg::word_t grad_pi;
    cswr_pkg::word_t grad_phi;
    cswr_pkg::word_t pi_value;
    cswr_pkg::word_t phi_value;
    cswr_pkg::word_t lapse_value;
    cswr_pkg::word_t shift_value;
    cswr_pkg::word_t grad_lapse;
    cswr_pkg::word_t grad_shift;
    cswr_pkg::word_t inv_metric;
    cswr_pkg::word_t christoffel_trace;
    cswr_pkg::word_t extrinsic_trace;

    modport source (
        output valid, grad_psi, grad_pi, grad_phi, pi_value, phi_value, lapse_value,
               shift_value, grad_lapse, grad_shift, inv_metric, christoffel_trace,
               extrinsic_trace,
        input  ready
    );
    modport sink (
        input  valid, grad_psi, grad_pi, grad_phi, pi_value, phi_value, lapse_value,
               shift_value, grad_lapse, grad_shift, inv_metric, christoffel_trace,
               extrinsic_trace,
        output ready
    );
endinterface

>>> hdl/cswr_out_if.sv
// Output channel: three time derivatives per item, valid/ready handshake.
// Depends on cswr_pkg.

interface cswr_out_if;
    logic            valid;
    logic            ready;
    cswr_pkg::word_t psi_rate;
    cswr_pkg::word_t pi_rate;
    cswr_pkg::word_t phi_rate;

    modport source (output valid, psi_rate, pi_rate, phi_rate, input ready);
    modport sink   (input valid, psi_rate, pi_rate, phi_rate, output ready);
endinterface

>>> hdl/cswr_cfg_if.sv
// Configuration write channel: register index and write data, valid/ready handshake.
// Depends on cswr_pkg.

interface cswr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cswr_pkg::CFG_IDX_W-1:0]   index;
    cswr_pkg::word_t                  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/cswr_cfg_regs.sv
// Damping register file (gamma1, gamma2) written over the configuration channel.
// Depends on cswr_pkg and cswr_cfg_if.

module cswr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    cswr_cfg_if.sink            cfg_ch,
    output cswr_pkg::cswr_cfg_t cfg
);
    import cswr_pkg::*;

    word_t gamma1_reg;
    word_t gamma2_reg;
    logic  gamma1_on_reg;

    // Always ready; writes to unknown indexes are dropped
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma1_reg    <= '0;
            gamma2_reg    <= '0;
            gamma1_on_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_GAMMA1:
                begin
                    gamma1_reg    <= cfg_ch.data;
                    gamma1_on_reg <= (cfg_ch.data != '0);
                end
                CFG_GAMMA2:
                begin
                    gamma2_reg <= cfg_ch.data;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.gamma1    = gamma1_reg;
    assign cfg.gamma2    = gamma2_reg;
    assign cfg.gamma1_on = gamma1_on_reg;

endmodule

>>> hdl/cswr_pipe_ctrl.sv
// Valid bits and per-stage load strobes for the datapath; bubbles collapse on stall.
// Depends on cswr_pkg.

module cswr_pipe_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output cswr_pkg::cswr_pipe_ctl_t ctl
);
    import cswr_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] advance;
    logic [PIPE_DEPTH-1:0] upstream;

    // A stage may take new data when it is empty or its item moves on
    always_comb
    begin
        advance[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
            advance[k] = !valid_reg[k] || advance[k+1];
    end

    // Valid feeding each stage
    always_comb
    begin
        upstream[0] = in_valid;
        for (int k = 1; k < PIPE_DEPTH; k++)
            upstream[k] = valid_reg[k-1];
    end

    always_comb
    begin
        for (int k = 0; k < PIPE_DEPTH; k++)
        begin
            valid_next[k]  = advance[k] ? upstream[k] : valid_reg[k];
            ctl.load[k]    = advance[k] && upstream[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = advance[0];
    assign out_valid = valid_reg[PIPE_DEPTH-1];

endmodule

>>> hdl/cswr_datapath.sv
// Five-stage fixed-point datapath: products, second products, partial sums, damping, output.
// Depends on cswr_pkg.

module cswr_datapath (
    input  logic                     clk,
    input  cswr_pkg::cswr_pipe_ctl_t ctl,
    input  cswr_pkg::cswr_cfg_t      cfg,
    input  cswr_pkg::point_t         point,
    output cswr_pkg::rates_t         rates
);
    import cswr_pkg::*;

    // Stage 1 registers
    word_t s1_pl_reg, s1_dps_reg, s1_sdpi_reg, s1_lc_reg, s1_lgi_reg, s1_gp_reg;
    word_t s1_lg2_reg, s1_nldpi_reg, s1_sdphi_reg, s1_dsub_reg, s1_pdl_reg;
    word_t s1_pds_reg, s1_ps_reg, s1_phi_reg, s1_dphi_reg, s1_dlapse_reg, s1_kt_reg;
    // Stage 2 registers
    word_t s2_rpi1_reg, s2_lcp_reg, s2_lgd_reg, s2_gpd_reg, s2_lgd2_reg, s2_c0_reg;
    word_t s2_rpsi0_reg, s2_rphi0_reg, s2_sdpi_reg, s2_pdl_reg, s2_pds_reg;
    // Stage 3 registers
    word_t s3_c_reg, s3_rpi_reg, s3_rphi_reg, s3_rpsi0_reg, s3_lgd_reg, s3_gpd_reg;
    word_t s3_pds_reg;
    // Stage 4 registers
    word_t s4_gc_reg, s4_rpsi_reg, s4_rpi_reg, s4_rphi_reg;
    // Output register
    rates_t out_reg;

    word_t s4_rpsi_next;
    word_t out_pi_next;

    // Stage 1: first-level products straight from the point
    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_pl_reg     <= q_mul(point.pi_value, point.lapse_value);
            s1_dps_reg    <= q_mul(point.grad_psi, point.shift_value);
            s1_sdpi_reg   <= q_mul(point.shift_value, point.grad_pi);
            s1_lc_reg     <= q_mul(point.lapse_value, point.christoffel_trace);
            s1_lgi_reg    <= q_mul(point.lapse_value, point.inv_metric);
            s1_gp_reg     <= q_mul(point.inv_metric, point.phi_value);
            s1_lg2_reg    <= q_mul(point.lapse_value, cfg.gamma2);
            s1_nldpi_reg  <= q_mul(q_neg(point.lapse_value), point.grad_pi);
            s1_sdphi_reg  <= q_mul(point.shift_value, point.grad_phi);
            s1_dsub_reg   <= q_sub(point.grad_psi, point.phi_value);
            s1_pdl_reg    <= q_mul(point.pi_value, point.grad_lapse);
            s1_pds_reg    <= q_mul(point.phi_value, point.grad_shift);
            s1_ps_reg     <= q_mul(point.phi_value, point.shift_value);
            s1_phi_reg    <= point.phi_value;
            s1_dphi_reg   <= point.grad_phi;
            s1_dlapse_reg <= point.grad_lapse;
            s1_kt_reg     <= point.extrinsic_trace;
        end
    end

    // Stage 2: second-level products and the first short sums
    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            s2_rpi1_reg  <= q_mul(s1_pl_reg, s1_kt_reg);
            s2_lcp_reg   <= q_mul(s1_lc_reg, s1_phi_reg);
            s2_lgd_reg   <= q_mul(s1_lgi_reg, s1_dphi_reg);
            s2_gpd_reg   <= q_mul(s1_gp_reg, s1_dlapse_reg);
            s2_lgd2_reg  <= q_mul(s1_lg2_reg, s1_dsub_reg);
            s2_c0_reg    <= q_sub(s1_dps_reg, s1_ps_reg);
            s2_rpsi0_reg <= q_add(q_neg(s1_pl_reg), s1_dps_reg);
            s2_rphi0_reg <= q_add(s1_nldpi_reg, s1_sdphi_reg);
            s2_sdpi_reg  <= s1_sdpi_reg;
            s2_pdl_reg   <= s1_pdl_reg;
            s2_pds_reg   <= s1_pds_reg;
        end
    end

    // Stage 3: gamma1 correction product, running sums for pi and phi
    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            s3_c_reg     <= q_mul(s2_c0_reg, cfg.gamma1);
            s3_rpi_reg   <= q_add(q_add(s2_rpi1_reg, s2_sdpi_reg), s2_lcp_reg);
            s3_rphi_reg  <= q_sub(q_add(s2_rphi0_reg, s2_lgd2_reg), s2_pdl_reg);
            s3_rpsi0_reg <= s2_rpsi0_reg;
            s3_lgd_reg   <= s2_lgd_reg;
            s3_gpd_reg   <= s2_gpd_reg;
            s3_pds_reg   <= s2_pds_reg;
        end
    end

    // Stage 4: gamma2 times correction, finish psi and phi
    assign s4_rpsi_next = cfg.gamma1_on ? q_add(s3_rpsi0_reg, s3_c_reg) : s3_rpsi0_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            s4_gc_reg   <= q_mul(cfg.gamma2, s3_c_reg);
            s4_rpsi_reg <= s4_rpsi_next;
            s4_rpi_reg  <= q_sub(q_sub(s3_rpi_reg, s3_lgd_reg), s3_gpd_reg);
            s4_rphi_reg <= q_add(s3_rphi_reg, s3_pds_reg);
        end
    end

    // Stage 5: output register, pi picks up the damped correction
    assign out_pi_next = cfg.gamma1_on ? q_add(s4_rpi_reg, s4_gc_reg) : s4_rpi_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            out_reg.psi_rate <= s4_rpsi_reg;
            out_reg.pi_rate  <= out_pi_next;
            out_reg.phi_rate <= s4_rphi_reg;
        end
    end

    assign rates = out_reg;

endmodule

>>> hdl/curved_scalar_wave_rhs_1d_unit.sv
// Curved-background first-order scalar wave RHS, one spatial dimension, Q16.16.
// Output valid follows the accepting edge through five register stages.
// Throughput: one item per cycle unless output stalls; stages at most one multiply deep.
// A stalled output keeps its item; upstream empty stages still fill.
// Reset (rst_n low, async) clears all valid bits and sets gamma1 and gamma2 to zero.
// Depends on cswr_pkg, the channel interfaces, cswr_cfg_regs, cswr_pipe_ctrl, cswr_datapath.

module curved_scalar_wave_rhs_1d_unit (
    input  logic     clk,
    input  logic     rst_n,
    cswr_in_if.sink  in_ch,
    cswr_out_if.source out_ch,
    cswr_cfg_if.sink cfg_ch
);
    import cswr_pkg::*;

    cswr_cfg_t      cfg;
    cswr_pipe_ctl_t ctl;
    point_t         point;
    rates_t         rates;

    // Pack the input fields
    assign point.grad_psi          = in_ch.grad_psi;
    assign point.grad_pi           = in_ch.grad_pi;
    assign point.grad_phi          = in_ch.grad_phi;
    assign point.pi_value          = in_ch.pi_value;
    assign point.phi_value         = in_ch.phi_value;
    assign point.lapse_value       = in_ch.lapse_value;
    assign point.shift_value       = in_ch.shift_value;
    assign point.grad_lapse        = in_ch.grad_lapse;
    assign point.grad_shift        = in_ch.grad_shift;
    assign point.inv_metric        = in_ch.inv_metric;
    assign point.christoffel_trace = in_ch.christoffel_trace;
    assign point.extrinsic_trace   = in_ch.extrinsic_trace;

    cswr_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    cswr_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl)
    );

    cswr_datapath u_dp (
        .clk   (clk),
        .ctl   (ctl),
        .cfg   (cfg),
        .point (point),
        .rates (rates)
    );

    // Unpack the result
    assign out_ch.psi_rate = rates.psi_rate;
    assign out_ch.pi_rate  = rates.pi_rate;
    assign out_ch.phi_rate = rates.phi_rate;

endmodule

>>> hdl/cswr_checker.sv
// Port-level checks for curved_scalar_wave_rhs_1d_unit, attached by bind below.
// Depends on cswr_pkg.

module cswr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input cswr_pkg::word_t psi_rate,
    input cswr_pkg::word_t pi_rate,
    input cswr_pkg::word_t phi_rate
);
    import cswr_pkg::*;

    localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_take;
    logic             out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    // Items accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_take && !out_take)
            occ_next = occ_reg + OCC_W'(1);
        else if (!in_take && out_take)
            occ_next = occ_reg - OCC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(psi_rate) && $stable(pi_rate)
                                    && $stable(phi_rate))
        else $error("stalled result changed");

    // No result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("result with nothing in flight");

    // Never more items in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // With the output empty the pipeline cannot refuse input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output stage");

endmodule

bind curved_scalar_wave_rhs_1d_unit cswr_checker u_cswr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .psi_rate  (out_ch.psi_rate),
    .pi_rate   (out_ch.pi_rate),
    .phi_rate  (out_ch.phi_rate)
);

>>> tb/curved_scalar_wave_rhs_1d_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for curved_scalar_wave_rhs_1d_unit: grid points in, Q16.16 rates out.
// Depends on cswr_pkg, the three channel interfaces and the unit itself.

module curved_scalar_wave_rhs_1d_unit_tb;

    import cswr_pkg::*;

    localparam word_t Q_ONE        = 32'sh0001_0000;
    localparam word_t Q_QUARTER    = 32'sh0000_4000;
    localparam word_t Q_ONE_HALF   = 32'sh0001_8000;
    localparam word_t RAW_ONE      = 32'sh0000_0001;
    localparam int    POINT_FIELDS = 12;
    localparam int    RANDOM_POINTS = 220;
    localparam int    HOLD_LEN     = 80;
    localparam int    REPORT_LIMIT = 10;
    // Index past the register list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = {CFG_IDX_W{1'b1}};

    // Expected-rate store with its own copy of the damping settings
    class wave_rate_checker;
        word_t  gamma1;
        word_t  gamma2;
        rates_t expected_rates[$];
        int     mismatches;
        int     checked;

        function new();
            gamma1     = '0;
            gamma2     = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_damping(logic [CFG_IDX_W-1:0] idx, word_t value);
            if (idx == CFG_GAMMA1)
                gamma1 = value;
            else if (idx == CFG_GAMMA2)
                gamma2 = value;
        endfunction

        function word_t clamp_word(longint v);
            if (v > longint'(WORD_MAX))
                return WORD_MAX;
            if (v < longint'(WORD_MIN))
                return WORD_MIN;
            return word_t'(v);
        endfunction

        function word_t sat_sum(word_t a, word_t b);
            return clamp_word(longint'(a) + longint'(b));
        endfunction

        function word_t sat_diff(word_t a, word_t b);
            return clamp_word(longint'(a) - longint'(b));
        endfunction

        function word_t sat_negate(word_t a);
            return clamp_word(-longint'(a));
        endfunction

        // Exact product, floor shift, then clamp
        function word_t fx_product(word_t a, word_t b);
            longint prod;
            prod = longint'(a) * longint'(b);
            return clamp_word(prod >>> FRAC_BITS);
        endfunction

        // Note an accepted point: work out its three rates
        function void predict_rates(point_t p);
            word_t  pl;
            word_t  dps;
            word_t  lg2;
            word_t  corr;
            rates_t r;
            pl  = fx_product(p.pi_value, p.lapse_value);
            dps = fx_product(p.grad_psi, p.shift_value);
            r.psi_rate = sat_sum(sat_negate(pl), dps);

            r.pi_rate = fx_product(pl, p.extrinsic_trace);
            r.pi_rate = sat_sum(r.pi_rate, fx_product(p.shift_value, p.grad_pi));
            r.pi_rate = sat_sum(r.pi_rate, fx_product(fx_product(p.lapse_value,
                                p.christoffel_trace), p.phi_value));
            r.pi_rate = sat_diff(r.pi_rate, fx_product(fx_product(p.lapse_value,
                                 p.inv_metric), p.grad_phi));
            r.pi_rate = sat_diff(r.pi_rate, fx_product(fx_product(p.inv_metric,
                                 p.phi_value), p.grad_lapse));

            lg2 = fx_product(p.lapse_value, gamma2);
            r.phi_rate = fx_product(sat_negate(p.lapse_value), p.grad_pi);
            r.phi_rate = sat_sum(r.phi_rate, fx_product(p.shift_value, p.grad_phi));
            r.phi_rate = sat_sum(r.phi_rate,
                                 fx_product(lg2, sat_diff(p.grad_psi, p.phi_value)));
            r.phi_rate = sat_diff(r.phi_rate, fx_product(p.pi_value, p.grad_lapse));
            r.phi_rate = sat_sum(r.phi_rate, fx_product(p.phi_value, p.grad_shift));

            // gamma1 correction only when enabled
            if (gamma1 != 0) begin
                corr = sat_diff(dps, fx_product(p.phi_value, p.shift_value));
                corr = fx_product(corr, gamma1);
                r.psi_rate = sat_sum(r.psi_rate, corr);
                r.pi_rate  = sat_sum(r.pi_rate, fx_product(gamma2, corr));
            end
            expected_rates.push_back(r);
        endfunction

        function int pending();
            return expected_rates.size();
        endfunction

        // Check one accepted result against the oldest expectation
        function void compare_rates(rates_t got);
            rates_t want;
            if (expected_rates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result psi %h pi %h phi %h",
                             $realtime, got.psi_rate, got.pi_rate, got.phi_rate);
                return;
            end
            want = expected_rates.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result %0d: exp psi %h pi %h phi %h, got psi %h pi %h phi %h",
                             $realtime, checked, want.psi_rate, want.pi_rate, want.phi_rate,
                             got.psi_rate, got.pi_rate, got.phi_rate);
            end
        endfunction

        // Anything still queued at the end never came out
        function void close_out();
            if (expected_rates.size() != 0) begin
                $display("%0d expected results never arrived", expected_rates.size());
                mismatches += expected_rates.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cswr_in_if  in_ch ();
    cswr_out_if out_ch ();
    cswr_cfg_if cfg_ch ();

    curved_scalar_wave_rhs_1d_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    wave_rate_checker rate_check;
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;
    int hold_cycles     = 0;
    int longest_hold    = 0;
    int points_sent     = 0;
    int cfg_writes      = 0;
    int unused_writes   = 0;
    int settings_run    = 0;

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Run limit
    initial begin
        #2_400_000;
        $display("timeout waiting for results");
        $display("curved_scalar_wave_rhs_1d_unit: mismatch");
        $finish;
    end

    // Result side: random stalls, or a counted hold-off when requested
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready = 1'b0;
            hold_cycles  = hold_cycles - 1;
        end else begin
            out_ch.ready = receiver_steady || ($urandom_range(99) >= 27);
        end
    end

    // Monitor both channels at the rising edge; result first, then new point
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready)
                rate_check.compare_rates({out_ch.psi_rate, out_ch.pi_rate, out_ch.phi_rate});
            if (in_ch.valid && in_ch.ready)
                rate_check.predict_rates({in_ch.grad_psi, in_ch.grad_pi, in_ch.grad_phi,
                                          in_ch.pi_value, in_ch.phi_value,
                                          in_ch.lapse_value, in_ch.shift_value,
                                          in_ch.grad_lapse, in_ch.grad_shift,
                                          in_ch.inv_metric, in_ch.christoffel_trace,
                                          in_ch.extrinsic_trace});
        end
    end

    // Mostly Q16.16 values of modest size, with extremes and raw words mixed in
    function automatic word_t random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(5))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                3:       return Q_ONE;
                4:       return -Q_ONE;
                default: return -RAW_ONE;
            endcase
        end
        if (pick < 35)
            return word_t'($urandom);
        if (pick < 75)
            return word_t'(int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
        return word_t'(int'($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000);
    endfunction

    function automatic point_t random_point();
        point_t p;
        for (int j = 0; j < POINT_FIELDS; j++)
            p[j*DATA_W +: DATA_W] = random_word();
        return p;
    endfunction

    // Corner points: extremes, negation and subtraction overflow, floor rounding
    function automatic point_t corner_point(int k);
        point_t p;
        p = {POINT_FIELDS{Q_ONE}};
        case (k)
            0: p = '0;
            1: p = {POINT_FIELDS{Q_ONE}};
            2: p = {POINT_FIELDS{WORD_MAX}};
            3: p = {POINT_FIELDS{WORD_MIN}};
            4: p = {POINT_FIELDS{-Q_ONE}};
            5: p = {POINT_FIELDS{-RAW_ONE}};
            6: p.pi_value = WORD_MIN;         // pi*lapse hits the minimum, negation clamps
            7: p.lapse_value = WORD_MIN;      // negated lapse clamps
            8: for (int j = 0; j < POINT_FIELDS; j++)
                   p[j*DATA_W +: DATA_W] = j[0] ? WORD_MIN : WORD_MAX;
            9: for (int j = 0; j < POINT_FIELDS; j++)
                   p[j*DATA_W +: DATA_W] = j[0] ? WORD_MAX : WORD_MIN;
            10: begin
                p.grad_psi    = WORD_MAX;     // grad_psi - phi overflows
                p.phi_value   = WORD_MIN;
                p.shift_value = WORD_MAX;
            end
            default: for (int j = 0; j < POINT_FIELDS; j++)
                   p[j*DATA_W +: DATA_W] = j[0] ? -RAW_ONE : RAW_ONE;
        endcase
        return p;
    endfunction

    // Offer one point and hold it until accepted
    task automatic send_point(point_t p);
        @(negedge clk);
        while (!sender_steady && $urandom_range(99) < 27) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.grad_psi          = p.grad_psi;
        in_ch.grad_pi           = p.grad_pi;
        in_ch.grad_phi          = p.grad_phi;
        in_ch.pi_value          = p.pi_value;
        in_ch.phi_value         = p.phi_value;
        in_ch.lapse_value       = p.lapse_value;
        in_ch.shift_value       = p.shift_value;
        in_ch.grad_lapse        = p.grad_lapse;
        in_ch.grad_shift        = p.grad_shift;
        in_ch.inv_metric        = p.inv_metric;
        in_ch.christoffel_trace = p.christoffel_trace;
        in_ch.extrinsic_trace   = p.extrinsic_trace;
        in_ch.valid             = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        points_sent++;
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic drain_rates();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (rate_check.pending() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, word_t value);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        rate_check.set_damping(idx, value);
        cfg_writes++;
        if (idx != CFG_GAMMA1 && idx != CFG_GAMMA2)
            unused_writes++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_damping_pair(word_t g1, word_t g2);
        write_register(CFG_GAMMA1, g1);
        write_register(CFG_GAMMA2, g2);
        settings_run++;
    endtask

    // Random points; optional output hold-off and a full drain partway
    task automatic run_random(int count, int hold_at, int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) begin
                hold_cycles  = HOLD_LEN;
                longest_hold = HOLD_LEN;
            end
            if (i == pause_at)
                drain_rates();
            send_point(random_point());
        end
        drain_rates();
    endtask

    initial begin
        rate_check   = new();
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.grad_psi = '0;          in_ch.grad_pi = '0;       in_ch.grad_phi = '0;
        in_ch.pi_value = '0;          in_ch.phi_value = '0;     in_ch.lapse_value = '0;
        in_ch.shift_value = '0;       in_ch.grad_lapse = '0;    in_ch.grad_shift = '0;
        in_ch.inv_metric = '0;        in_ch.christoffel_trace = '0;
        in_ch.extrinsic_trace = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner points at reset settings, then with extreme damping
        settings_run++;
        for (int k = 0; k < 12; k++)
            send_point(corner_point(k));
        drain_rates();
        set_damping_pair(WORD_MIN, WORD_MAX);
        for (int k = 0; k < 12; k++)
            send_point(corner_point(k));
        drain_rates();

        // gamma1 off, gamma2 on
        set_damping_pair('0, Q_ONE_HALF);
        run_random(RANDOM_POINTS, -1, -1);

        // Random damping; sender waits for a full drain midway
        set_damping_pair(random_word(), random_word());
        run_random(RANDOM_POINTS, -1, RANDOM_POINTS / 2);

        set_damping_pair(WORD_MAX, WORD_MIN);
        run_random(RANDOM_POINTS, -1, -1);

        // Back-to-back stretch with a long output hold-off; spare index ignored
        set_damping_pair(-Q_QUARTER, '0);
        write_register(CFG_UNUSED, word_t'($urandom));
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        run_random(RANDOM_POINTS, 40, -1);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;

        set_damping_pair(word_t'($urandom), word_t'($urandom));
        run_random(RANDOM_POINTS, -1, -1);

        rate_check.close_out();
        $display("Sent %0d grid points, checked %0d results over %0d damping settings.",
                 points_sent, rate_check.checked, settings_run);
        $display("%0d register writes (%0d to an unused index), output held off %0d cycles.",
                 cfg_writes, unused_writes, longest_hold);
        if (rate_check.mismatches == 0)
            $display("curved_scalar_wave_rhs_1d_unit: match");
        else
            $display("curved_scalar_wave_rhs_1d_unit: mismatch");
        $finish;
    end

endmodule
